/* design/ksc_pkg.sv */
// Shared types and constants for the keyword substitution cipher.
// No dependencies; every other file imports this package.
package ksc_pkg;

  localparam int NumLetters = 26;
  localparam int NumKey     = 5;
  localparam int LetterW    = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 5;
  localparam int CharInW    = 8;
  localparam int CharOutW   = 7;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegKeyFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKeySecond = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyThird  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyFourth = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyFifth  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDirection = 3'd5;

  localparam logic [CharInW-1:0]  CharSpace = 8'd32;
  localparam logic [CharInW-1:0]  CharLowA  = 8'd97;
  localparam logic [CharInW-1:0]  CharLowZ  = 8'd122;
  localparam logic [CharInW-1:0]  CharUpA   = 8'd65;
  localparam logic [CharInW-1:0]  CharUpZ   = 8'd90;
  localparam logic [CharOutW-1:0] OutSpace  = 7'd32;
  localparam logic [CharOutW-1:0] OutLowA   = 7'd97;

  typedef logic [LetterW-1:0]    letter_t;
  typedef logic [NumLetters-1:0] lmask_t;

  // cipher tables derived from the key, plus the direction bit
  typedef struct packed {
    letter_t [NumLetters-1:0] enc;     // plain letter -> cipher letter
    letter_t [NumLetters-1:0] dec;     // cipher letter -> plain letter
    lmask_t                   dec_ok;  // cipher letter has a slot
    logic                     decrypt;
  } ksc_map_t;

endpackage

/* design/ksc_ifs.sv */
// Valid/ready channel interfaces: character input, character output, config write.
// Depends on ksc_pkg.
interface ksc_in_if import ksc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CharInW-1:0] char_in;
  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ksc_out_if import ksc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CharOutW-1:0] char_out;
  modport source (output valid, output char_out, input ready);
  modport sink   (input valid, input char_out, output ready);
endinterface

interface ksc_cfg_if import ksc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/ksc_table.sv */
// Configuration registers and the registered cipher tables built from them.
// Depends on ksc_pkg and ksc_cfg_if.
module ksc_table import ksc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ksc_cfg_if.sink   cfg,
  output ksc_map_t  tables
);

  letter_t [NumKey-1:0] key;
  logic                 direction;
  ksc_map_t             tables_next;

  function automatic letter_t fold_letter(logic [CfgDataW-1:0] v);
    letter_t r;
    if (v >= LetterW'(NumLetters)) begin
      r = v - LetterW'(NumLetters);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NumKey; k++) begin
        key[k] <= LetterW'(k);
      end
      direction <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index <= RegKeyFifth) begin
        key[cfg.index] <= fold_letter(cfg.data);
      end else if (cfg.index == RegDirection) begin
        direction <= cfg.data[0];
      end
    end
  end

  // non-key letters take slots 5.. in alphabetical order; key letters take
  // the lowest slot that names them
  always_comb begin
    lmask_t                   in_key;
    letter_t [NumLetters-1:0] nk_pos;
    lmask_t                   below;
    in_key = '0;
    for (int l = 0; l < NumLetters; l++) begin
      for (int k = 0; k < NumKey; k++) begin
        if (key[k] == LetterW'(l)) in_key[l] = 1'b1;
      end
    end
    for (int l = 0; l < NumLetters; l++) begin
      below     = NumLetters'((NumLetters+1)'(1) << l) - NumLetters'(1);
      nk_pos[l] = LetterW'(NumKey) + LetterW'($countones(~in_key & below));
    end
    tables_next.decrypt = direction;
    for (int l = 0; l < NumLetters; l++) begin
      tables_next.dec[l]    = nk_pos[l];
      tables_next.dec_ok[l] = nk_pos[l] < LetterW'(NumLetters);
      for (int k = NumKey - 1; k >= 0; k--) begin
        if (key[k] == LetterW'(l)) tables_next.dec[l] = LetterW'(k);
      end
      if (in_key[l]) tables_next.dec_ok[l] = 1'b1;
    end
    for (int p = 0; p < NumLetters; p++) begin
      tables_next.enc[p] = '0;
      if (p < NumKey) begin
        tables_next.enc[p] = key[p];
      end else begin
        for (int l = 0; l < NumLetters; l++) begin
          if (!in_key[l] && nk_pos[l] == LetterW'(p)) tables_next.enc[p] = LetterW'(l);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tables <= tables_next;
  end

endmodule

/* design/ksc_map.sv */
// Two-register character path: input register, table lookup, result register.
// Depends on ksc_pkg, ksc_in_if and ksc_out_if.
module ksc_map import ksc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ksc_map_t tables,
  ksc_in_if.sink   feed,
  ksc_out_if.source result
);

  logic                valid_in;
  logic [CharInW-1:0]  char_reg;
  logic                valid_out;
  logic [CharOutW-1:0] char_out_reg;

  logic                has_result;
  logic [CharOutW-1:0] mapped;
  logic                out_free;
  logic                advance;

  always_comb begin
    letter_t p;
    logic    is_lower;
    logic    is_upper;
    is_lower   = char_reg >= CharLowA && char_reg <= CharLowZ;
    is_upper   = char_reg >= CharUpA && char_reg <= CharUpZ;
    p          = is_lower ? LetterW'(char_reg - CharLowA) : LetterW'(char_reg - CharUpA);
    has_result = 1'b0;
    mapped     = OutSpace;
    if (char_reg == CharSpace) begin
      has_result = 1'b1;
    end else if (is_lower || is_upper) begin
      if (tables.decrypt) begin
        has_result = tables.dec_ok[p];
        mapped     = OutLowA + CharOutW'(tables.dec[p]);
      end else begin
        has_result = 1'b1;
        mapped     = OutLowA + CharOutW'(tables.enc[p]);
      end
    end
  end

  assign out_free   = !valid_out || result.ready;
  // a word with no result leaves without waiting on the output side
  assign advance    = valid_in && (!has_result || out_free);
  assign feed.ready = !rst && (!valid_in || advance);

  assign result.valid    = valid_out;
  assign result.char_out = char_out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_in  <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      if (feed.valid && feed.ready) begin
        valid_in <= 1'b1;
      end else if (advance) begin
        valid_in <= 1'b0;
      end
      if (advance && has_result) begin
        valid_out <= 1'b1;
      end else if (result.ready) begin
        valid_out <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (feed.valid && feed.ready) char_reg <= feed.char_in;
    if (advance && has_result) char_out_reg <= mapped;
  end

endmodule

/* design/keyword_substitution_cipher_top.sv */
// Keyword substitution cipher, one character word per cycle sustained while the output side is ready.
// Path: an accepted word is held in the input register, then written to the result register once the output is free.
// One word per cycle while result.ready is high; result.ready reaches feed.ready combinationally.
// Tables are rebuilt from the key registers every cycle into a table register, which a config write passes first.
// Reset (rst, synchronous): key letters a..e, encrypt, pipeline empty; no ready during reset.
module keyword_substitution_cipher_top import ksc_pkg::*; (
  input logic       clk,
  input logic       rst,
  ksc_cfg_if.sink   cfg,
  ksc_in_if.sink    feed,
  ksc_out_if.source result
);

  ksc_map_t tables;

  ksc_table u_table (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tables (tables)
  );

  ksc_map u_map (
    .clk    (clk),
    .rst    (rst),
    .tables (tables),
    .feed   (feed),
    .result (result)
  );

endmodule
